/* hw/rtl/battery_voltage_alarm_supervisor_top_assert.svh */
// ---------------------------------------------------------------------------
// Battery voltage alarm supervisor assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_ALARM_SUPERVISOR_TOP_ASSERT_SVH
`define BATTERY_VOLTAGE_ALARM_SUPERVISOR_TOP_ASSERT_SVH

`ifndef SYNTH

// Check a property on every rising edge, disabled while reset is held
`define BVAS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bvas assertion failed");

// Check a property on every rising edge, reset included
`define BVAS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bvas assertion failed");

`else

`define BVAS_ASSERT(lbl, clk, rst_n, prop)
`define BVAS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hw/rtl/bvas_pkg.sv */
// ---------------------------------------------------------------------------
// Battery voltage alarm supervisor package
// Widths, reset values, alarm periods and register index codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bvas_pkg;

    // Field widths
    localparam int SAMPLE_W  = 13;
    localparam int GAIN_W    = 24;
    localparam int MV_W      = 16;
    localparam int CHAN_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;

    // Configuration defaults
    localparam int               CHANNELS_DEFAULT = 4;
    localparam int               GAIN_REGS        = 4;
    localparam int               LEVEL_OUTPUTS    = 4;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 24'd727743;

    // Buzzer periods in ticks (powers of two)
    localparam int PERIOD_WARNING  = 64;
    localparam int PERIOD_UNSAFE   = 16;
    localparam int PERIOD_CRITICAL = 4;

    typedef logic [MV_W-1:0]   t_mv;
    typedef logic [GAIN_W-1:0] t_gain;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_WARNING  = 2'd1,
        ST_UNSAFE   = 2'd2,
        ST_CRITICAL = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_A   = 3'd0,
        CFG_GAIN_B   = 3'd1,
        CFG_GAIN_C   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_WARNING  = 3'd4,
        CFG_UNSAFE   = 3'd5,
        CFG_CRITICAL = 3'd6
    } t_cfg_index;

endpackage

`default_nettype wire

/* hw/rtl/battery_voltage_alarm_supervisor_top.sv */
// An input transfer is captured in the input register; the result register loads from it
// when it is free. Throughput: one item per cycle while the result side does not stall;
// the result stage does one 13x24 multiply, three threshold compares per level and the
// status decode combinationally. An input register and the result register let a new item
// enter while a result waits. Synchronous active-low reset empties both stages, clears
// levels, status, button history and tick count, and loads the default gains.
// ---------------------------------------------------------------------------
// Battery voltage alarm supervisor top level
// Scales channel samples to millivolts, tracks alarm status, drives the piezo.
// ---------------------------------------------------------------------------
`default_nettype none

`include "battery_voltage_alarm_supervisor_top_assert.svh"

module battery_voltage_alarm_supervisor_top #(
    parameter int CHANNELS = bvas_pkg::CHANNELS_DEFAULT
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_sample_valid,
    input  wire  [bvas_pkg::CHAN_W-1:0]       i_channel,
    input  wire  [bvas_pkg::SAMPLE_W-1:0]     i_sample_mv,
    input  wire                               i_test_button,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [1:0]                        o_alarm_status,
    output logic                              o_piezo_on,
    output logic [bvas_pkg::MV_W-1:0]         o_level_a_mv,
    output logic [bvas_pkg::MV_W-1:0]         o_level_b_mv,
    output logic [bvas_pkg::MV_W-1:0]         o_level_c_mv,
    output logic [bvas_pkg::MV_W-1:0]         o_level_d_mv,
    // configuration write channel
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [bvas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bvas_pkg::GAIN_W-1:0]       i_cfg_data
);

    // Configuration registers
    bvas_pkg::t_gain r_gain [bvas_pkg::GAIN_REGS];
    bvas_pkg::t_mv   r_warn_level;
    bvas_pkg::t_mv   r_unsafe_level;
    bvas_pkg::t_mv   r_crit_level;

    // Input stage
    logic                            r_s1_valid;
    logic                            r_s1_sample_valid;
    logic [bvas_pkg::CHAN_W-1:0]     r_s1_channel;
    logic [bvas_pkg::SAMPLE_W-1:0]   r_s1_sample;
    logic                            r_s1_button;

    // Supervisor state
    bvas_pkg::t_mv      r_level [CHANNELS];
    bvas_pkg::t_status  r_status;
    logic               r_last_button;
    logic [15:0]        r_tick;

    // Result register
    logic               r_out_valid;
    bvas_pkg::t_status  r_out_status;
    logic               r_out_piezo;
    bvas_pkg::t_mv      r_out_level [bvas_pkg::LEVEL_OUTPUTS];

    // Result-stage next values
    logic                            s1_advance;
    logic                            s2_fire;
    logic                            in_fire;
    logic [bvas_pkg::PROD_W-1:0]     product;
    bvas_pkg::t_mv                   scaled_mv;
    bvas_pkg::t_mv                   n_level [CHANNELS];
    bvas_pkg::t_mv                   n_out_level [bvas_pkg::LEVEL_OUTPUTS];
    logic                            below_crit;
    logic                            below_unsafe;
    logic                            below_warn;
    bvas_pkg::t_status               n_status;
    logic                            n_piezo;

    // Handshake: the input stage moves on when the result register is free
    always_comb begin
        s1_advance  = !r_out_valid || !i_out_stall;
        s2_fire     = r_s1_valid && s1_advance;
        o_in_stall  = r_s1_valid && !s1_advance;
        in_fire     = i_in_valid && !o_in_stall;
        o_cfg_ready = 1'b1;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bvas_pkg::GAIN_REGS; i++) begin
                r_gain[i] <= bvas_pkg::GAIN_RESET;
            end
            r_warn_level   <= '0;
            r_unsafe_level <= '0;
            r_crit_level   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bvas_pkg::CFG_GAIN_A:   r_gain[0] <= i_cfg_data;
                bvas_pkg::CFG_GAIN_B:   r_gain[1] <= i_cfg_data;
                bvas_pkg::CFG_GAIN_C:   r_gain[2] <= i_cfg_data;
                bvas_pkg::CFG_GAIN_D:   r_gain[3] <= i_cfg_data;
                bvas_pkg::CFG_WARNING:  r_warn_level   <= i_cfg_data[bvas_pkg::MV_W-1:0];
                bvas_pkg::CFG_UNSAFE:   r_unsafe_level <= i_cfg_data[bvas_pkg::MV_W-1:0];
                bvas_pkg::CFG_CRITICAL: r_crit_level   <= i_cfg_data[bvas_pkg::MV_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Input register: capture on transfer, empty when passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sample_valid <= i_sample_valid;
            r_s1_channel      <= i_channel;
            r_s1_sample       <= i_sample_mv;
            r_s1_button       <= i_test_button;
        end
    end

    // Scale the sample to millivolts and saturate
    always_comb begin
        product = bvas_pkg::PROD_W'(r_s1_sample) * bvas_pkg::PROD_W'(r_gain[r_s1_channel]);
        if (|product[bvas_pkg::PROD_W-1:bvas_pkg::FRAC_W+bvas_pkg::MV_W]) begin
            scaled_mv = '1;
        end else begin
            scaled_mv = product[bvas_pkg::FRAC_W+bvas_pkg::MV_W-1:bvas_pkg::FRAC_W];
        end
    end

    // Store the new level and compare all levels against the thresholds
    always_comb begin
        below_crit   = 1'b0;
        below_unsafe = 1'b0;
        below_warn   = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_s1_sample_valid && (32'(r_s1_channel) == i)) begin
                n_level[i] = scaled_mv;
            end else begin
                n_level[i] = r_level[i];
            end
            below_crit   = below_crit   | (n_level[i] < r_crit_level);
            below_unsafe = below_unsafe | (n_level[i] < r_unsafe_level);
            below_warn   = below_warn   | (n_level[i] < r_warn_level);
        end
    end

    // Status: thresholds from critical down, else button falling edge advances
    always_comb begin
        if (below_crit) begin
            n_status = bvas_pkg::ST_CRITICAL;
        end else if (below_unsafe) begin
            n_status = bvas_pkg::ST_UNSAFE;
        end else if (below_warn) begin
            n_status = bvas_pkg::ST_WARNING;
        end else if (r_last_button && !r_s1_button) begin
            n_status = bvas_pkg::t_status'(r_status + 2'd1);
        end else begin
            n_status = r_status;
        end
    end

    // Piezo pulse on tick counts that are a multiple of the status period
    always_comb begin
        unique case (n_status)
            bvas_pkg::ST_NORMAL:
                n_piezo = 1'b0;
            bvas_pkg::ST_WARNING:
                n_piezo = (r_tick & 16'(bvas_pkg::PERIOD_WARNING - 1)) == '0;
            bvas_pkg::ST_UNSAFE:
                n_piezo = (r_tick & 16'(bvas_pkg::PERIOD_UNSAFE - 1)) == '0;
            bvas_pkg::ST_CRITICAL:
                n_piezo = (r_tick & 16'(bvas_pkg::PERIOD_CRITICAL - 1)) == '0;
            default:
                n_piezo = 1'b0;
        endcase
    end

    // Level outputs with no channel behind them read zero
    for (genvar g = 0; g < bvas_pkg::LEVEL_OUTPUTS; g++) begin : g_level_out
        if (g < CHANNELS) begin : g_used
            assign n_out_level[g] = n_level[g];
        end else begin : g_unused
            assign n_out_level[g] = '0;
        end
    end

    // Supervisor state update per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i] <= '0;
            end
            r_status      <= bvas_pkg::ST_NORMAL;
            r_last_button <= 1'b0;
            r_tick        <= '0;
        end else if (s2_fire) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i] <= n_level[i];
            end
            r_status      <= n_status;
            r_last_button <= r_s1_button;
            r_tick        <= r_tick + 16'd1;
        end
    end

    // Result register: load on a processed item, drop after its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_status <= n_status;
            r_out_piezo  <= n_piezo;
            for (int j = 0; j < bvas_pkg::LEVEL_OUTPUTS; j++) begin
                r_out_level[j] <= n_out_level[j];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_alarm_status = r_out_status;
    assign o_piezo_on     = r_out_piezo;
    assign o_level_a_mv   = r_out_level[0];
    assign o_level_b_mv   = r_out_level[1];
    assign o_level_c_mv   = r_out_level[2];
    assign o_level_d_mv   = r_out_level[3];

    // Assertions
    `BVAS_ASSERT(a_piezo_needs_alarm, i_clk, i_rst_n, (r_out_valid && r_out_piezo) |-> (r_out_status != bvas_pkg::ST_NORMAL))
    `BVAS_ASSERT(a_tick_per_item, i_clk, i_rst_n, s2_fire |=> (r_tick == $past(r_tick) + 16'd1))
    `BVAS_ASSERT(a_stall_only_full, i_clk, i_rst_n, o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
    `BVAS_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!r_out_valid && !r_s1_valid))

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// Battery voltage alarm supervisor testbench
// Plays sample ticks and register writes into the supervisor, predicts the
// status reading of every tick and checks the result stream field by field
// while the input side idles and the result side stalls at random.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int NUM_CH        = bvas_pkg::CHANNELS_DEFAULT;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASES        = 6;
    localparam int PHASE_TICKS   = 150;

    typedef enum logic [1:0] {
        STEP_TICK,
        STEP_WRITE,
        STEP_SETTLE
    } t_step_kind;

    typedef struct packed {
        t_step_kind                     kind;
        logic                           sample_valid;
        logic [bvas_pkg::CHAN_W-1:0]    channel;
        logic [bvas_pkg::SAMPLE_W-1:0]  sample_mv;
        logic                           test_button;
        bvas_pkg::t_cfg_index           reg_index;
        bvas_pkg::t_gain                reg_data;
    } t_plan_step;

    typedef struct packed {
        bvas_pkg::t_status                           status;
        logic                                        piezo;
        bvas_pkg::t_mv [bvas_pkg::LEVEL_OUTPUTS-1:0] level;
    } t_reading;

    // Clock, reset and block inputs
    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_in_valid     = 1'b0;
    logic                            i_sample_valid = 1'b0;
    logic [bvas_pkg::CHAN_W-1:0]     i_channel      = '0;
    logic [bvas_pkg::SAMPLE_W-1:0]   i_sample_mv    = '0;
    logic                            i_test_button  = 1'b0;
    logic                            i_out_stall    = 1'b0;
    logic                            i_cfg_valid    = 1'b0;
    logic [bvas_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [bvas_pkg::GAIN_W-1:0]     i_cfg_data     = '0;

    // Block outputs
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [1:0]                  o_alarm_status;
    logic                        o_piezo_on;
    logic [bvas_pkg::MV_W-1:0]   o_level_a_mv;
    logic [bvas_pkg::MV_W-1:0]   o_level_b_mv;
    logic [bvas_pkg::MV_W-1:0]   o_level_c_mv;
    logic [bvas_pkg::MV_W-1:0]   o_level_d_mv;
    logic                        o_cfg_ready;

    // Stimulus plan and pending predictions
    t_plan_step tick_plan [$];
    t_reading   pending_readings [$];

    // Predicted supervisor state
    bvas_pkg::t_gain    gain_of [bvas_pkg::GAIN_REGS];
    bvas_pkg::t_mv      warn_mv;
    bvas_pkg::t_mv      unsafe_mv;
    bvas_pkg::t_mv      crit_mv;
    bvas_pkg::t_mv      level_of [bvas_pkg::LEVEL_OUTPUTS];
    bvas_pkg::t_status  status_now;
    logic               button_was;
    logic [15:0]        tick_no;

    // Handshake flags seen at the last rising edge
    logic tick_taken  = 1'b0;
    logic write_taken = 1'b0;

    int ticks_in      = 0;
    int readings_seen = 0;
    int mismatches    = 0;

    int gap_left    = 0;
    int burst_left  = 0;
    int settle_left = SETTLE_CYCLES;
    int stall_left  = 0;
    int calm_left   = 0;
    int hold_left   = 0;
    int next_hold   = 120;

    battery_voltage_alarm_supervisor_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_valid (i_sample_valid),
        .i_channel      (i_channel),
        .i_sample_mv    (i_sample_mv),
        .i_test_button  (i_test_button),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alarm_status (o_alarm_status),
        .o_piezo_on     (o_piezo_on),
        .o_level_a_mv   (o_level_a_mv),
        .o_level_b_mv   (o_level_b_mv),
        .o_level_c_mv   (o_level_c_mv),
        .o_level_d_mv   (o_level_d_mv),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Generate the clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Check whether any stored level sits below a threshold
    function automatic logic any_level_below(input bvas_pkg::t_mv limit);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (level_of[i] < limit) hit = 1'b1;
        end
        return hit;
    endfunction

    // Advance the predicted state by one tick and form its reading
    task automatic predict_tick(input t_plan_step s, output t_reading r);
        logic [bvas_pkg::PROD_W-1:0]                  prod;
        logic [bvas_pkg::PROD_W-bvas_pkg::FRAC_W-1:0] scaled;
        logic [1:0]                                   stepped;
        int                                           period;
        period = 0;
        if (s.sample_valid && int'(s.channel) < NUM_CH) begin
            prod   = s.sample_mv * gain_of[s.channel];
            scaled = prod[bvas_pkg::PROD_W-1:bvas_pkg::FRAC_W];
            if (scaled[bvas_pkg::PROD_W-bvas_pkg::FRAC_W-1:bvas_pkg::MV_W] != 0)
                level_of[s.channel] = {bvas_pkg::MV_W{1'b1}};
            else
                level_of[s.channel] = scaled[bvas_pkg::MV_W-1:0];
        end
        if (any_level_below(crit_mv)) begin
            status_now = bvas_pkg::ST_CRITICAL;
        end else if (any_level_below(unsafe_mv)) begin
            status_now = bvas_pkg::ST_UNSAFE;
        end else if (any_level_below(warn_mv)) begin
            status_now = bvas_pkg::ST_WARNING;
        end else if (button_was && !s.test_button) begin
            stepped    = status_now + 2'd1;
            status_now = bvas_pkg::t_status'(stepped);
        end
        case (status_now)
            bvas_pkg::ST_WARNING:  period = bvas_pkg::PERIOD_WARNING;
            bvas_pkg::ST_UNSAFE:   period = bvas_pkg::PERIOD_UNSAFE;
            bvas_pkg::ST_CRITICAL: period = bvas_pkg::PERIOD_CRITICAL;
            default:               period = 0;
        endcase
        r.status   = status_now;
        r.piezo    = (period != 0) && ((int'(tick_no) % period) == 0);
        button_was = s.test_button;
        tick_no    = tick_no + 16'd1;
        for (int j = 0; j < bvas_pkg::LEVEL_OUTPUTS; j++) begin
            r.level[j] = (j < NUM_CH) ? level_of[j] : '0;
        end
    endtask

    // Apply a register write to the predicted settings
    task automatic apply_write(input bvas_pkg::t_cfg_index idx, input bvas_pkg::t_gain data);
        case (idx)
            bvas_pkg::CFG_GAIN_A:   gain_of[0] = data;
            bvas_pkg::CFG_GAIN_B:   gain_of[1] = data;
            bvas_pkg::CFG_GAIN_C:   gain_of[2] = data;
            bvas_pkg::CFG_GAIN_D:   gain_of[3] = data;
            bvas_pkg::CFG_WARNING:  warn_mv    = data[bvas_pkg::MV_W-1:0];
            bvas_pkg::CFG_UNSAFE:   unsafe_mv  = data[bvas_pkg::MV_W-1:0];
            bvas_pkg::CFG_CRITICAL: crit_mv    = data[bvas_pkg::MV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [bvas_pkg::MV_W-1:0] got,
                                   input logic [bvas_pkg::MV_W-1:0] want);
        mismatches++;
        $display("mismatch in %s at reading %0d: got %0d, want %0d",
                 what, readings_seen, got, want);
    endtask

    task automatic add_tick(input logic sv, input logic [bvas_pkg::CHAN_W-1:0] ch,
                            input logic [bvas_pkg::SAMPLE_W-1:0] mv, input logic btn);
        t_plan_step s;
        s              = '0;
        s.kind         = STEP_TICK;
        s.sample_valid = sv;
        s.channel      = ch;
        s.sample_mv    = mv;
        s.test_button  = btn;
        tick_plan.push_back(s);
    endtask

    task automatic add_write(input bvas_pkg::t_cfg_index idx, input bvas_pkg::t_gain data);
        t_plan_step s;
        s           = '0;
        s.kind      = STEP_WRITE;
        s.reg_index = idx;
        s.reg_data  = data;
        tick_plan.push_back(s);
    endtask

    task automatic add_settle();
        t_plan_step s;
        s      = '0;
        s.kind = STEP_SETTLE;
        tick_plan.push_back(s);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_send_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        return pick_gap();
    endfunction

    function automatic bvas_pkg::t_gain pick_gain(input int ph, input int lane);
        case (ph)
            0:       return bvas_pkg::GAIN_RESET;
            1:       return (lane == 1 || lane == 2) ? {bvas_pkg::GAIN_W{1'b1}} : '0;
            default: return bvas_pkg::GAIN_W'($urandom_range(32'h8000, 32'hA0000));
        endcase
    endfunction

    // Watch both transfers: predict accepted ticks, check accepted readings
    always @(posedge i_clk) begin : watch_proc
        t_reading want;
        tick_taken  = 1'b0;
        write_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("reading with none pending", o_alarm_status, '0);
                end else begin
                    want = pending_readings.pop_front();
                    if (o_alarm_status !== want.status)
                        report_mismatch("alarm_status", o_alarm_status, want.status);
                    if (o_piezo_on !== want.piezo)
                        report_mismatch("piezo_on", o_piezo_on, want.piezo);
                    if (o_level_a_mv !== want.level[0])
                        report_mismatch("level_a_mv", o_level_a_mv, want.level[0]);
                    if (o_level_b_mv !== want.level[1])
                        report_mismatch("level_b_mv", o_level_b_mv, want.level[1]);
                    if (o_level_c_mv !== want.level[2])
                        report_mismatch("level_c_mv", o_level_c_mv, want.level[2]);
                    if (o_level_d_mv !== want.level[3])
                        report_mismatch("level_d_mv", o_level_d_mv, want.level[3]);
                end
                readings_seen++;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                write_taken = 1'b1;
                apply_write(bvas_pkg::t_cfg_index'(i_cfg_index), i_cfg_data);
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                tick_taken = 1'b1;
                predict_tick({STEP_TICK, i_sample_valid, i_channel, i_sample_mv,
                              i_test_button, bvas_pkg::CFG_GAIN_A,
                              {bvas_pkg::GAIN_W{1'b0}}}, want);
                pending_readings.push_back(want);
                ticks_in++;
            end
        end
    end

    // Feed ticks and register writes from the plan
    always @(negedge i_clk) begin : drive_proc
        t_plan_step s;
        logic       keep_tick;
        logic       keep_write;
        keep_tick  = i_in_valid && !tick_taken;
        keep_write = i_cfg_valid && !write_taken;
        if (i_rst_n && !keep_tick && !keep_write) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (tick_plan.size() != 0) begin
                s = tick_plan[0];
                case (s.kind)
                    STEP_TICK: begin
                        void'(tick_plan.pop_front());
                        i_sample_valid <= s.sample_valid;
                        i_channel      <= s.channel;
                        i_sample_mv    <= s.sample_mv;
                        i_test_button  <= s.test_button;
                        keep_tick      = 1'b1;
                        gap_left       = next_send_gap();
                    end
                    STEP_WRITE: begin
                        void'(tick_plan.pop_front());
                        i_cfg_index <= s.reg_index;
                        i_cfg_data  <= s.reg_data;
                        keep_write  = 1'b1;
                    end
                    default: begin
                        // Hold until every reading is back and the pipe is quiet
                        if (pending_readings.size() != 0) begin
                            settle_left = SETTLE_CYCLES;
                        end else if (settle_left > 0) begin
                            settle_left--;
                        end else begin
                            void'(tick_plan.pop_front());
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                endcase
            end
        end
        i_in_valid  <= keep_tick;
        i_cfg_valid <= keep_write;
    end

    // Stall the result side: random gaps, calm stretches and long hold-offs
    always @(negedge i_clk) begin : stall_proc
        logic stall;
        int   r;
        stall = 1'b0;
        if (!i_rst_n) begin
            stall = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
        end else if (ticks_in >= next_hold) begin
            hold_left = HOLD_CYCLES - 1;
            next_hold += 300;
            stall     = 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
        end else if (stall_left > 0) begin
            stall_left--;
            stall = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                calm_left = $urandom_range(20, 80);
            end else if (r >= 65) begin
                stall_left = pick_gap() - 1;
                stall      = 1'b1;
            end
        end
        i_out_stall <= stall;
    end

    // Stop a hung run
    initial begin
        #6000000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        bvas_pkg::t_mv w;
        bvas_pkg::t_mv u;
        bvas_pkg::t_mv c;
        int            r;

        // Predicted state after reset
        for (int i = 0; i < bvas_pkg::GAIN_REGS; i++) gain_of[i] = bvas_pkg::GAIN_RESET;
        for (int i = 0; i < bvas_pkg::LEVEL_OUTPUTS; i++) level_of[i] = '0;
        warn_mv    = '0;
        unsafe_mv  = '0;
        crit_mv    = '0;
        status_now = bvas_pkg::ST_NORMAL;
        button_was = 1'b0;
        tick_no    = '0;

        // Default settings: no threshold trips, the button walks the status
        // through every value and wraps; samples at both ends, two saturating
        add_tick(1'b1, 2'd0, 13'd0,    1'b0);
        add_tick(1'b1, 2'd1, 13'd8191, 1'b1);
        add_tick(1'b1, 2'd2, 13'd1,    1'b0);
        add_tick(1'b1, 2'd3, 13'd5902, 1'b1);
        add_tick(1'b0, 2'd0, 13'd8191, 1'b0);
        add_tick(1'b0, 2'd1, 13'd0,    1'b1);
        add_tick(1'b0, 2'd2, 13'd4095, 1'b0);
        add_tick(1'b0, 2'd3, 13'd0,    1'b1);
        add_tick(1'b1, 2'd0, 13'd4096, 1'b0);
        add_tick(1'b1, 2'd1, 13'h1555, 1'b1);
        add_tick(1'b1, 2'd2, 13'h0aaa, 1'b1);

        // Ordered thresholds, zero and full-scale gains
        add_settle();
        add_write(bvas_pkg::CFG_GAIN_A,   '0);
        add_write(bvas_pkg::CFG_GAIN_B,   {bvas_pkg::GAIN_W{1'b1}});
        add_write(bvas_pkg::CFG_GAIN_C,   24'h080000);
        add_write(bvas_pkg::CFG_GAIN_D,   bvas_pkg::GAIN_RESET);
        add_write(bvas_pkg::CFG_WARNING,  24'd30000);
        add_write(bvas_pkg::CFG_UNSAFE,   24'd20000);
        add_write(bvas_pkg::CFG_CRITICAL, 24'd10000);
        add_tick(1'b1, 2'd2, 13'd1000, 1'b0);
        add_tick(1'b1, 2'd2, 13'd2000, 1'b1);
        add_tick(1'b1, 2'd2, 13'd3000, 1'b0);
        add_tick(1'b1, 2'd2, 13'd5000, 1'b1);
        add_tick(1'b1, 2'd2, 13'd5000, 1'b0);
        add_tick(1'b1, 2'd1, 13'd1,    1'b1);
        add_tick(1'b1, 2'd1, 13'd8191, 1'b0);
        add_tick(1'b1, 2'd0, 13'd8191, 1'b1);

        // New thresholds; gain change leaves stored levels alone
        add_settle();
        add_write(bvas_pkg::CFG_GAIN_A,   24'h020000);
        add_write(bvas_pkg::CFG_WARNING,  24'd65535);
        add_write(bvas_pkg::CFG_UNSAFE,   24'd60000);
        add_write(bvas_pkg::CFG_CRITICAL, 24'd100);
        add_tick(1'b1, 2'd0, 13'd8191, 1'b0);
        add_tick(1'b1, 2'd3, 13'd0,    1'b1);
        add_tick(1'b0, 2'd3, 13'd8191, 1'b0);

        // Random phases, each with a fresh set of registers
        for (int ph = 0; ph < PHASES; ph++) begin
            add_settle();
            add_write(bvas_pkg::CFG_GAIN_A, pick_gain(ph, 0));
            add_write(bvas_pkg::CFG_GAIN_B, pick_gain(ph, 1));
            add_write(bvas_pkg::CFG_GAIN_C, pick_gain(ph, 2));
            add_write(bvas_pkg::CFG_GAIN_D, pick_gain(ph, 3));
            case (ph)
                0: begin
                    w = '0;
                    u = '0;
                    c = '0;
                end
                1: begin
                    w = '1;
                    u = '1;
                    c = '1;
                end
                4: begin
                    w = bvas_pkg::MV_W'($urandom_range(0, 65535));
                    u = bvas_pkg::MV_W'($urandom_range(0, 65535));
                    c = bvas_pkg::MV_W'($urandom_range(0, 65535));
                end
                default: begin
                    w = bvas_pkg::MV_W'($urandom_range(20000, 60000));
                    u = bvas_pkg::MV_W'($urandom_range(0, w));
                    c = bvas_pkg::MV_W'($urandom_range(0, u));
                end
            endcase
            add_write(bvas_pkg::CFG_WARNING,  bvas_pkg::GAIN_W'(w));
            add_write(bvas_pkg::CFG_UNSAFE,   bvas_pkg::GAIN_W'(u));
            add_write(bvas_pkg::CFG_CRITICAL, bvas_pkg::GAIN_W'(c));
            for (int n = 0; n < PHASE_TICKS; n++) begin
                r = $urandom_range(0, 99);
                add_tick(r < 80, bvas_pkg::CHAN_W'($urandom_range(0, 3)),
                         ($urandom_range(0, 1) != 0)
                             ? bvas_pkg::SAMPLE_W'($urandom_range(0, 8191))
                             : bvas_pkg::SAMPLE_W'($urandom_range(5000, 8191)),
                         1'($urandom_range(0, 1)));
            end
        end

        // Release reset once, at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain the plan and every pending reading, then let the pipe settle
        while (tick_plan.size() != 0 || i_in_valid || i_cfg_valid ||
               pending_readings.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
